// File: design/ppmfd_pkg.sv
package ppmfd_pkg;

  // Field widths of the capture word, the decoded result and the configuration port.
  localparam int unsigned StampW   = 16;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned ChanIdxW = 4;
  localparam int unsigned ExpChW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Default channel capacity of one frame.
  localparam int unsigned MaxChannelsDef = 16;

  // Register reset values.
  localparam logic [StampW-1:0] SyncGapRst  = 16'd3000;
  localparam logic [StampW-1:0] PreambleRst = 16'd600;
  localparam logic [StampW-1:0] PulseMinRst = 16'd800;
  localparam logic [StampW-1:0] PulseMaxRst = 16'd2200;
  localparam logic [ExpChW-1:0] ExpChAny    = 8'hff;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgSyncGapMin  = 3'd0,
    CfgPreambleMax = 3'd1,
    CfgPulseMin    = 3'd2,
    CfgPulseMax    = 3'd3,
    CfgExpChannels = 3'd4
  } ppmfd_cfg_idx_e;

  // Kind of event reported for each capture word.
  typedef enum logic [2:0] {
    KindPreamble = 3'd0,
    KindChannel  = 3'd1,
    KindFrameOk  = 3'd2,
    KindFrameBad = 3'd3,
    KindLock     = 3'd4
  } ppmfd_kind_e;

  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic              pin_level;
  } ppmfd_in_t;

  typedef struct packed {
    ppmfd_kind_e         event_kind;
    logic [ChanIdxW-1:0] channel_index;
    logic [StampW-1:0]   pulse_width;
    logic [StampW-1:0]   frame_period;
    logic [SlotW-1:0]    channel_count;
    logic                hold;
  } ppmfd_out_t;

  typedef struct packed {
    logic [StampW-1:0] sync_gap_min;
    logic [StampW-1:0] preamble_max;
    logic [StampW-1:0] pulse_min;
    logic [StampW-1:0] pulse_max;
    logic [ExpChW-1:0] expected_channels;
  } ppmfd_cfg_t;

endpackage

// File: design/ppmfd_cfg.sv
module ppmfd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ppmfd_pkg::CfgDataW-1:0]      cfg_data_i,
  output ppmfd_pkg::ppmfd_cfg_t               cfg_o
);
  import ppmfd_pkg::*;

  ppmfd_cfg_t cfg_d, cfg_q;

  // Decode the register index; unused indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ppmfd_cfg_idx_e'(cfg_idx_i))
        CfgSyncGapMin:  cfg_d.sync_gap_min      = cfg_data_i[StampW-1:0];
        CfgPreambleMax: cfg_d.preamble_max      = cfg_data_i[StampW-1:0];
        CfgPulseMin:    cfg_d.pulse_min         = cfg_data_i[StampW-1:0];
        CfgPulseMax:    cfg_d.pulse_max         = cfg_data_i[StampW-1:0];
        CfgExpChannels: cfg_d.expected_channels = cfg_data_i[ExpChW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gap_min      <= SyncGapRst;
      cfg_q.preamble_max      <= PreambleRst;
      cfg_q.pulse_min         <= PulseMinRst;
      cfg_q.pulse_max         <= PulseMaxRst;
      cfg_q.expected_channels <= ExpChAny;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/ppmfd_dec.sv
module ppmfd_dec #(
  parameter int unsigned MaxChannels = ppmfd_pkg::MaxChannelsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ppmfd_pkg::ppmfd_in_t   word_i,
  input  ppmfd_pkg::ppmfd_cfg_t  cfg_i,
  output ppmfd_pkg::ppmfd_out_t  res_o
);
  import ppmfd_pkg::*;

  localparam logic [SlotW-1:0] SlotLimit = SlotW'(MaxChannels);

  logic [StampW-1:0] prev_q, prev_d;
  logic [StampW-1:0] total_q, total_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              locked_q, locked_d;
  logic [StampW-1:0] pre_q, pre_d;
  logic              idle_q, idle_d;
  logic              hold_q, hold_d;

  logic [StampW-1:0] gap;
  logic [StampW-1:0] total_sum;
  logic [StampW-1:0] width;
  logic              is_sync;
  logic              count_ok;
  logic              width_ok;

  // Tick arithmetic wraps with the 16-bit timer.
  assign gap       = word_i.stamp - prev_q;
  assign total_sum = total_q + gap;
  assign width     = gap + pre_q;
  assign is_sync   = gap > cfg_i.sync_gap_min;
  assign count_ok  = (cfg_i.expected_channels == ExpChAny) ||
                     (cfg_i.expected_channels == ExpChW'(slot_q));
  assign width_ok  = (width > cfg_i.pulse_min) && (width < cfg_i.pulse_max) &&
                     (slot_q < SlotLimit);

  // Classify the edge and work out the next decoder state.
  always_comb begin
    prev_d   = word_i.stamp;
    total_d  = total_sum;
    slot_d   = slot_q;
    locked_d = locked_q;
    pre_d    = pre_q;
    idle_d   = idle_q;
    hold_d   = hold_q;
    res_o    = '0;

    if (is_sync) begin
      res_o.frame_period  = total_sum;
      res_o.channel_count = slot_q;
      if (!locked_q && count_ok) begin
        res_o.event_kind = KindFrameOk;
        hold_d           = 1'b0;
      end else begin
        res_o.event_kind = KindFrameBad;
        hold_d           = 1'b1;
      end
      idle_d   = ~word_i.pin_level;
      total_d  = '0;
      slot_d   = '0;
      locked_d = 1'b0;
    end else if (word_i.pin_level != idle_q) begin
      // Edge away from idle closes a channel pulse.
      if (!locked_q && width_ok) begin
        res_o.event_kind    = KindChannel;
        res_o.channel_index = slot_q[ChanIdxW-1:0];
        res_o.pulse_width   = width;
        slot_d              = slot_q + SlotW'(1);
      end else begin
        res_o.event_kind = KindLock;
        locked_d         = 1'b1;
        hold_d           = 1'b1;
      end
    end else begin
      // Edge back to idle closes the preamble.
      if (!locked_q && (gap < cfg_i.preamble_max)) begin
        res_o.event_kind = KindPreamble;
        pre_d            = gap;
      end else begin
        res_o.event_kind = KindLock;
        locked_d         = 1'b1;
      end
    end
    res_o.hold = hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      total_q  <= '0;
      slot_q   <= '0;
      locked_q <= 1'b0;
      pre_q    <= '0;
      idle_q   <= 1'b0;
      hold_q   <= 1'b0;
    end else if (en_i) begin
      prev_q   <= prev_d;
      total_q  <= total_d;
      slot_q   <= slot_d;
      locked_q <= locked_d;
      pre_q    <= pre_d;
      idle_q   <= idle_d;
      hold_q   <= hold_d;
    end
  end

endmodule

// File: design/ppm_frame_decoder_core.sv
// A word accepted into the input register moves into the result register once that
// register is free or being drained; its result word is then offered at the output.
// Throughput: one word per cycle while the output is not stalled; the decoder state
// is updated as the word moves from the input register into the result register.
// Reset (asynchronous, active low) clears the decoder state and the valid flags of
// both pipeline registers and returns the configuration registers to their defaults.
module ppm_frame_decoder_core #(
  parameter int unsigned MaxChannels = ppmfd_pkg::MaxChannelsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ppmfd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ppmfd_pkg::ppmfd_in_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ppmfd_pkg::ppmfd_out_t           out_data_o
);
  import ppmfd_pkg::*;

  ppmfd_cfg_t cfg;
  ppmfd_out_t res;

  logic       in_valid_q, in_valid_d;
  ppmfd_in_t  in_word_q;
  logic       out_valid_q, out_valid_d;
  ppmfd_out_t out_word_q;
  logic       advance;
  logic       accept;

  ppmfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ppmfd_dec #(
    .MaxChannels (MaxChannels)
  ) u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .word_i (in_word_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // A held word moves on when the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_data_i;
    end
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

// File: design/ppmfd_checker.sv
module ppmfd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  ppmfd_pkg::ppmfd_out_t           out_data_o
);
  import ppmfd_pkg::*;

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // A result appears only for a word that was taken in through the input register.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire, 2))
    else $error("result word without an accepted capture word");

  // Only frame ends report period and count.
  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != KindFrameOk &&
    out_data_o.event_kind != KindFrameBad |->
    out_data_o.frame_period == '0 && out_data_o.channel_count == '0)
    else $error("frame fields set on a non-frame event");

  // A good frame releases hold, a rejected one sets it.
  a_frame_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_kind == KindFrameOk ||
    out_data_o.event_kind == KindFrameBad) |->
    out_data_o.hold == (out_data_o.event_kind == KindFrameBad))
    else $error("hold flag does not follow the frame verdict");

  // Only channel events carry a slot and a width.
  a_chan_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_kind != KindChannel |->
    out_data_o.channel_index == '0 && out_data_o.pulse_width == '0)
    else $error("channel fields set on a non-channel event");

endmodule

bind ppm_frame_decoder_core ppmfd_checker u_ppmfd_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

import ppmfd_pkg::*;

// Tracks the decoder state from the accepted capture words and checks every
// decoded word against the predicted one, in order.
class ppm_event_scoreboard;
  ppmfd_cfg_t        regs;
  logic [StampW-1:0] last_stamp;
  logic [StampW-1:0] frame_ticks;
  logic [StampW-1:0] preamble_len;
  logic [SlotW-1:0]  slot;
  logic              locked_q;
  logic              idle_lvl;
  logic              hold_q;
  ppmfd_out_t        expected_events[$];
  int unsigned       mismatches;
  int unsigned       kind_count[5];

  function new();
    regs.sync_gap_min      = SyncGapRst;
    regs.preamble_max      = PreambleRst;
    regs.pulse_min         = PulseMinRst;
    regs.pulse_max         = PulseMaxRst;
    regs.expected_channels = ExpChAny;
    last_stamp   = '0;
    frame_ticks  = '0;
    preamble_len = '0;
    slot         = '0;
    locked_q     = 1'b0;
    idle_lvl     = 1'b0;
    hold_q       = 1'b0;
    mismatches   = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
  endfunction

  function void write_reg(ppmfd_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgSyncGapMin:  regs.sync_gap_min = data;
      CfgPreambleMax: regs.preamble_max = data;
      CfgPulseMin:    regs.pulse_min = data;
      CfgPulseMax:    regs.pulse_max = data;
      CfgExpChannels: regs.expected_channels = data[ExpChW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the decoder state by one capture word and queue the decoded word.
  function void note_capture(ppmfd_in_t cap);
    logic [StampW-1:0] gap;
    logic [StampW-1:0] width;
    ppmfd_out_t        want;
    want = '0;
    gap = cap.stamp - last_stamp;
    frame_ticks = frame_ticks + gap;
    if (gap > regs.sync_gap_min) begin
      // A long gap closes the frame; the count only matters when unlocked.
      want.frame_period  = frame_ticks;
      want.channel_count = slot;
      if (!locked_q && (regs.expected_channels == ExpChAny ||
                        regs.expected_channels == slot)) begin
        want.event_kind = KindFrameOk;
        hold_q = 1'b0;
      end else begin
        want.event_kind = KindFrameBad;
        hold_q = 1'b1;
      end
      idle_lvl    = ~cap.pin_level;
      frame_ticks = '0;
      slot        = '0;
      locked_q    = 1'b0;
    end else if (cap.pin_level != idle_lvl) begin
      // Edge away from idle: a channel ends, its width includes the preamble.
      width = gap + preamble_len;
      if (!locked_q && width > regs.pulse_min && width < regs.pulse_max &&
          slot < MaxChannelsDef) begin
        want.event_kind    = KindChannel;
        want.channel_index = slot[ChanIdxW-1:0];
        want.pulse_width   = width;
        slot = slot + 1'b1;
      end else begin
        want.event_kind = KindLock;
        locked_q = 1'b1;
        hold_q   = 1'b1;
      end
    end else begin
      // Edge back to idle: a preamble ends.
      if (!locked_q && gap < regs.preamble_max) begin
        want.event_kind = KindPreamble;
        preamble_len = gap;
      end else begin
        want.event_kind = KindLock;
        locked_q = 1'b1;
      end
    end
    last_stamp = cap.stamp;
    want.hold = hold_q;
    expected_events.push_back(want);
  endfunction

  function void check_event(ppmfd_out_t got);
    ppmfd_out_t want;
    if (expected_events.size() == 0) begin
      $error("decoded word with no pending expectation: event_kind %0d", got.event_kind);
      mismatches++;
      return;
    end
    want = expected_events.pop_front();
    kind_count[want.event_kind]++;
    if (got.event_kind !== want.event_kind) begin
      $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
      mismatches++;
    end
    if (got.channel_index !== want.channel_index) begin
      $error("channel_index: expected %0d, actual %0d", want.channel_index, got.channel_index);
      mismatches++;
    end
    if (got.pulse_width !== want.pulse_width) begin
      $error("pulse_width: expected %0d, actual %0d", want.pulse_width, got.pulse_width);
      mismatches++;
    end
    if (got.frame_period !== want.frame_period) begin
      $error("frame_period: expected %0d, actual %0d", want.frame_period, got.frame_period);
      mismatches++;
    end
    if (got.channel_count !== want.channel_count) begin
      $error("channel_count: expected %0d, actual %0d", want.channel_count, got.channel_count);
      mismatches++;
    end
    if (got.hold !== want.hold) begin
      $error("hold: expected %0d, actual %0d", want.hold, got.hold);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam int unsigned RunLimit    = 600000;
  localparam int unsigned DrainCycles = 6;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ppmfd_in_t           in_word  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ppmfd_out_t          out_word;

  ppm_event_scoreboard sb = new();
  int unsigned         cycles        = 0;
  int unsigned         words_sent    = 0;
  int unsigned         settings_used = 0;
  logic [StampW-1:0]   stamp_now     = '0;
  bit                  no_gaps       = 1'b0;

  ppm_frame_decoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RunLimit) begin
      $display("ppm_frame_decoder_core regression: fail");
      $finish;
    end
  end

  // Every decoded word taken at an edge goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      sb.check_event(out_word);
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  // Back-pressure on the decoded words, with long stretches of steady ready.
  initial begin : ready_driver
    int unsigned hold_for;
    bit          level;
    hold_for = 0;
    level    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_for == 0) begin
        level = !level;
        if (level) begin
          hold_for = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 300)
                                                 : $urandom_range(1, 20);
        end else begin
          hold_for = idle_len();
        end
        out_ready <= level;
      end else begin
        hold_for--;
      end
    end
  end

  // Present one capture word a given number of ticks after the previous one.
  task automatic send_delta(input int unsigned delta, input logic pin);
    ppmfd_in_t   cap;
    int unsigned gap;
    stamp_now = stamp_now + delta[StampW-1:0];
    cap.stamp     = stamp_now;
    cap.pin_level = pin;
    in_valid <= 1'b1;
    in_word  <= cap;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    sb.note_capture(cap);
    words_sent++;
    gap = no_gaps ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every decoded word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input ppmfd_cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Write all registers while the decoder is idle.
  task automatic apply_settings(input ppmfd_cfg_t s);
    logic [7:0] pad;
    pad = $urandom_range(0, 255);
    settle();
    put_reg(CfgSyncGapMin, s.sync_gap_min);
    put_reg(CfgPreambleMax, s.preamble_max);
    put_reg(CfgPulseMin, s.pulse_min);
    put_reg(CfgPulseMax, s.pulse_max);
    // The upper byte is junk; only the low byte holds the count.
    put_reg(CfgExpChannels, {pad, s.expected_channels});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed frames under the current settings: a sync edge, then
  // preamble and channel edges in turn. Some frames carry one spoiled edge,
  // and a few bursts are pure noise.
  task automatic run_frames(input int unsigned quota);
    int unsigned stop_at, want_ch, n_ch, total, spoil_at, k, d, pre, hi, wdt;
    logic        lvl, pin;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      want_ch = sb.regs.expected_channels;
      if ($urandom_range(0, 19) == 0) begin
        no_gaps = 1'b0;
        repeat ($urandom_range(1, 6)) begin
          send_delta($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 1000),
                     $urandom_range(0, 1));
        end
      end else begin
        if (want_ch <= MaxChannelsDef && $urandom_range(0, 9) < 6) begin
          n_ch = want_ch;
        end else if ($urandom_range(0, 9) == 0) begin
          n_ch = $urandom_range(16, 17);
        end else begin
          n_ch = $urandom_range(0, 12);
        end
        total    = 1 + 2 * n_ch;
        spoil_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
        no_gaps  = ($urandom_range(0, 3) == 0);
        lvl      = $urandom_range(0, 1);
        pre      = 0;
        for (k = 0; k < total; k++) begin
          if (k == 0) begin
            // Sync edge; when no gap can exceed the threshold, anything goes.
            pin = lvl;
            if (sb.regs.sync_gap_min == 16'hffff) begin
              d = $urandom_range(0, 65535);
            end else begin
              hi = int'(sb.regs.sync_gap_min) + 6000;
              if (hi > 65535) hi = 65535;
              d = $urandom_range(int'(sb.regs.sync_gap_min) + 1, hi);
            end
          end else if (k % 2 == 1) begin
            // Preamble below its limit where the limit allows, and not above the sync threshold.
            pin = ~lvl;
            if (sb.regs.preamble_max == 0) begin
              pre = 0;
            end else begin
              hi = int'(sb.regs.preamble_max) - 1;
              if (hi > sb.regs.sync_gap_min) hi = sb.regs.sync_gap_min;
              pre = $urandom_range(hi / 4, hi);
            end
            d = pre;
          end else begin
            // Channel whose width, preamble included, falls inside the limits where they leave room.
            pin = lvl;
            if (int'(sb.regs.pulse_max) > int'(sb.regs.pulse_min) + 1) begin
              wdt = $urandom_range(int'(sb.regs.pulse_min) + 1, int'(sb.regs.pulse_max) - 1);
            end else begin
              wdt = $urandom_range(0, 65535);
            end
            d = (wdt - pre) & 32'hffff;
          end
          if (k == spoil_at) begin
            case ($urandom_range(0, 2))
              0:       pin = ~pin;
              1:       d = $urandom_range(0, 65535);
              default: d = d + $urandom_range(200, 3000);
            endcase
          end
          send_delta(d, pin);
        end
      end
    end
  endtask

  initial begin : stimulus
    ppmfd_cfg_t  s;
    int unsigned r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset settings.
    send_delta(5000, 1'b1);   // first sync, any count accepted
    send_delta(400, 1'b0);    // preamble
    send_delta(1100, 1'b1);   // ordinary channel
    send_delta(300, 1'b0);
    send_delta(1899, 1'b1);   // width one below the upper limit
    send_delta(599, 1'b0);    // preamble one below its limit
    send_delta(202, 1'b1);    // width one above the lower limit
    send_delta(300, 1'b0);
    send_delta(500, 1'b1);    // width equal to the lower limit locks
    send_delta(300, 1'b0);    // preamble while locked
    send_delta(3001, 1'b1);   // sync while locked rejects the frame
    send_delta(600, 1'b0);    // preamble equal to its limit locks
    send_delta(3000, 1'b0);   // gap equal to the threshold is no sync
    send_delta(65535, 1'b1);  // largest gap, frame rejected
    send_delta(0, 1'b0);      // zero gap preamble
    send_delta(2199, 1'b1);   // channel without preamble ticks
    send_delta(3500, 1'b0);   // good frame with one channel clears hold
    send_delta(100, 1'b1);
    send_delta(2100, 1'b0);   // width equal to the upper limit locks

    run_frames(330);

    // Typical eight-channel receiver.
    s = '{sync_gap_min: 16'd3000, preamble_max: 16'd500, pulse_min: 16'd900,
          pulse_max: 16'd2100, expected_channels: 8'd8};
    apply_settings(s);
    run_frames(250);

    // Limits wide open: widths and frame totals wrap.
    s = '{sync_gap_min: 16'd60000, preamble_max: 16'hffff, pulse_min: 16'd0,
          pulse_max: 16'hffff, expected_channels: ExpChAny};
    apply_settings(s);
    run_frames(120);

    // Every register at its lowest value.
    s = '{sync_gap_min: 16'd0, preamble_max: 16'd0, pulse_min: 16'd0,
          pulse_max: 16'd0, expected_channels: 8'd0};
    apply_settings(s);
    run_frames(50);

    // Timing registers at their highest value, 16 channels expected; no gap can reach sync.
    s = '{sync_gap_min: 16'hffff, preamble_max: 16'hffff, pulse_min: 16'hffff,
          pulse_max: 16'hffff, expected_channels: 8'd16};
    apply_settings(s);
    run_frames(50);

    // Random realistic settings.
    repeat (4) begin
      s.sync_gap_min = $urandom_range(2500, 20000);
      s.preamble_max = $urandom_range(150, 700);
      s.pulse_min    = $urandom_range(400, 1100);
      s.pulse_max    = $urandom_range(1500, 3000);
      r = $urandom_range(0, 9);
      if (r < 3) s.expected_channels = ExpChAny;
      else if (r < 9) s.expected_channels = $urandom_range(0, 16);
      else s.expected_channels = $urandom_range(17, 254);
      apply_settings(s);
      run_frames(90);
    end

    settle();
    $display("Sent %0d capture words over %0d register settings: %0d preambles, %0d channels,",
             words_sent, settings_used + 1, sb.kind_count[KindPreamble],
             sb.kind_count[KindChannel]);
    $display("%0d good frames, %0d rejected frames and %0d lock events decoded.",
             sb.kind_count[KindFrameOk], sb.kind_count[KindFrameBad], sb.kind_count[KindLock]);
    if (sb.mismatches == 0) begin
      $display("ppm_frame_decoder_core regression: pass");
    end else begin
      $display("ppm_frame_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/ppmfd_pkg.sv
design/ppmfd_cfg.sv
design/ppmfd_dec.sv
design/ppm_frame_decoder_core.sv
design/ppmfd_checker.sv
verif/tb.sv
